// ===== hw/rtl/gamepad_serial_poll_assert.svh =====
// Assertion macros for the gamepad serial poll block.
`ifndef GAMEPAD_SERIAL_POLL_ASSERT_SVH
`define GAMEPAD_SERIAL_POLL_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define GSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define GSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/gsp_pkg.sv =====
// Shared types, constants and the command byte table of the gamepad poller.
package gsp_pkg;

    localparam int unsigned RESP_BYTES = 7;
    localparam logic [3:0]  CMD_BYTES  = 4'd9;
    localparam logic [3:0]  MODE_BYTE  = 4'd1;
    localparam logic [3:0]  FIRST_KEPT = 4'd3;
    localparam logic [3:0]  LAST_KEPT  = 4'd8;
    localparam logic [2:0]  LAST_BIT   = 3'd7;
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd200;

    localparam logic [7:0] CMD_START = 8'h01;
    localparam logic [7:0] CMD_POLL  = 8'h42;
    localparam logic [7:0] CMD_IDLE  = 8'h00;

    localparam int unsigned OUT_TDATA_W = 64;

    typedef logic [7:0] byte_t;

    // Line levels and published response of one tick.
    typedef struct packed {
        logic  cs_n;
        logic  clk_line;
        logic  cmd_line;
        logic  busy;
        logic  done;
        byte_t mode_id;
        logic [15:0] buttons;
        byte_t right_x;
        byte_t right_y;
        byte_t left_x;
        byte_t left_y;
    } result_t;

    function automatic byte_t command_byte(input logic [3:0] idx);
        byte_t b;
        case (idx)
            4'd0:    b = CMD_START;
            4'd1:    b = CMD_POLL;
            default: b = CMD_IDLE;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/gsp_engine.sv =====
// Poll sequencer: clock divider, bit/byte counters, capture and publish.
module gsp_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              func,
    input  logic              din,
    input  logic [15:0]       half_period,
    output gsp_pkg::result_t  res
);

    logic                poll_active_reg, poll_active_next;
    logic                low_phase_reg, low_phase_next;
    logic [15:0]         tick_count_reg, tick_count_next;
    logic [2:0]          bit_index_reg, bit_index_next;
    logic [3:0]          byte_index_reg, byte_index_next;
    gsp_pkg::byte_t      shift_reg, shift_next;
    gsp_pkg::byte_t      cap_reg   [gsp_pkg::RESP_BYTES];
    gsp_pkg::byte_t      cap_next  [gsp_pkg::RESP_BYTES];
    gsp_pkg::byte_t      shown_reg [gsp_pkg::RESP_BYTES];
    gsp_pkg::byte_t      shown_next[gsp_pkg::RESP_BYTES];

    logic [15:0]         hp;
    logic [16:0]         tick_inc;
    gsp_pkg::byte_t      shift_full;
    logic [3:0]          byte_inc;
    logic                done;
    gsp_pkg::byte_t      cmd_byte;

    always_comb
    begin
        hp         = (half_period == 16'd0) ? 16'd1 : half_period;
        tick_inc   = {1'b0, tick_count_reg} + 17'd1;
        shift_full = shift_reg | (gsp_pkg::byte_t'(din) << bit_index_reg);
        byte_inc   = byte_index_reg + 4'd1;

        poll_active_next = poll_active_reg;
        low_phase_next   = low_phase_reg;
        tick_count_next  = tick_count_reg;
        bit_index_next   = bit_index_reg;
        byte_index_next  = byte_index_reg;
        shift_next       = shift_reg;
        cap_next         = cap_reg;
        shown_next       = shown_reg;
        done             = 1'b0;

        if (!poll_active_reg)
        begin
            if (func)
            begin
                poll_active_next = 1'b1;
                low_phase_next   = 1'b0;
                tick_count_next  = 16'd0;
                bit_index_next   = 3'd0;
                byte_index_next  = 4'd0;
                shift_next       = '0;
            end
        end
        else if (tick_inc >= {1'b0, hp})
        begin
            tick_count_next = 16'd0;
            if (!low_phase_reg)
            begin
                low_phase_next = 1'b1;
            end
            else
            begin
                low_phase_next = 1'b0;
                if (bit_index_reg != gsp_pkg::LAST_BIT)
                begin
                    bit_index_next = bit_index_reg + 3'd1;
                    shift_next     = shift_full;
                end
                else
                begin
                    if (byte_index_reg == gsp_pkg::MODE_BYTE)
                        cap_next[0] = shift_full;
                    else if (byte_index_reg inside
                             {[gsp_pkg::FIRST_KEPT:gsp_pkg::LAST_KEPT]})
                        cap_next[3'(byte_index_reg - 4'd2)] = shift_full;
                    bit_index_next  = 3'd0;
                    shift_next      = '0;
                    byte_index_next = byte_inc;
                    if (byte_inc >= gsp_pkg::CMD_BYTES)
                    begin
                        poll_active_next = 1'b0;
                        byte_index_next  = 4'd0;
                        done             = 1'b1;
                        shown_next       = cap_next;
                    end
                end
            end
        end
        else
        begin
            tick_count_next = tick_inc[15:0];
        end

        cmd_byte = gsp_pkg::command_byte(byte_index_next);

        res.cs_n     = !poll_active_next;
        res.clk_line = !(poll_active_next && low_phase_next);
        res.cmd_line = poll_active_next ? cmd_byte[bit_index_next] : 1'b1;
        res.busy     = poll_active_next;
        res.done     = done;
        res.mode_id  = shown_next[0];
        res.buttons  = {shown_next[2], shown_next[1]};
        res.right_x  = shown_next[3];
        res.right_y  = shown_next[4];
        res.left_x   = shown_next[5];
        res.left_y   = shown_next[6];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_active_reg <= 1'b0;
            low_phase_reg   <= 1'b0;
            tick_count_reg  <= '0;
            bit_index_reg   <= '0;
            byte_index_reg  <= '0;
            shift_reg       <= '0;
            for (int i = 0; i < gsp_pkg::RESP_BYTES; i++)
            begin
                cap_reg[i]   <= '0;
                shown_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            poll_active_reg <= poll_active_next;
            low_phase_reg   <= low_phase_next;
            tick_count_reg  <= tick_count_next;
            bit_index_reg   <= bit_index_next;
            byte_index_reg  <= byte_index_next;
            shift_reg       <= shift_next;
            cap_reg         <= cap_next;
            shown_reg       <= shown_next;
        end
    end

endmodule

// ===== hw/rtl/gamepad_serial_poll.sv =====
// Top level of the gamepad serial poller: stream ports, config and pipeline registers.
// A request is held in the input register, then its result is loaded into the result register and offered on m_tvalid.
// Throughput: one request per cycle while the result side is not stalled; the sequencer steps once per request.
// The input register and the result register each take a new request while the other side waits.
// Reset (rst_n, async, active low): poll idle, published bytes zero, half period 200 ticks.
// After reset no request is pending and no result is offered.
`include "gamepad_serial_poll_assert.svh"

module gamepad_serial_poll (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: half period in ticks
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] data_in, [7:1] zero
    input  logic        s_tuser,   // [0] func: 0 tick, 1 start poll
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [gsp_pkg::OUT_TDATA_W-1:0] m_tdata
    // m_tdata fields, lowest bit up: [0] cs_n, [1] clk_line, [2] cmd_line, [3] busy_res,
    // [4] done_res, [12:5] mode_id, [28:13] buttons, [36:29] right_x, [44:37] right_y,
    // [52:45] left_x, [60:53] left_y, [63:61] zero
);

    logic [15:0]       half_period_reg;
    logic              in_valid_reg;
    logic              in_func_reg;
    logic              in_din_reg;
    logic              out_valid_reg;
    logic [gsp_pkg::OUT_TDATA_W-1:0] out_data_reg;

    logic              out_free;
    logic              advance;
    gsp_pkg::result_t  res;

    // The result register frees when empty or when its request is taken this edge.
    assign out_free = !out_valid_reg || m_tready;
    // Move the held request through the sequencer whenever its result has room.
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // Hold the half period; the user must write it only while the block is idle, the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_period_reg <= gsp_pkg::HALF_PERIOD_RESET;
        else if (cfg_we)
            half_period_reg <= cfg_wdata;
    end

    // Input register: capture a request, drop it once advanced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_func_reg <= s_tuser;
            in_din_reg  <= s_tdata[0];
        end
    end

    // Sequencer state advances by exactly one tick per advanced request.
    gsp_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .func        (in_func_reg),
        .din         (in_din_reg),
        .half_period (half_period_reg),
        .res         (res)
    );

    // Result register: load the state after the tick, hold it until taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= {3'b000, res.left_y, res.left_x, res.right_y, res.right_x,
                             res.buttons, res.mode_id, res.done, res.busy,
                             res.cmd_line, res.clk_line, res.cs_n};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A held request is never lost while the result side stalls.
    `GSP_ASSERT_NEXT(a_hold_request, in_valid_reg && !out_free, in_valid_reg, "request dropped while stalled")
    // Chip select is low exactly while a poll is busy.
    `GSP_ASSERT_NOW(a_cs_busy, m_tvalid, m_tdata[0] != m_tdata[3], "cs_n does not track busy")
    // A completing poll has already released the bus.
    `GSP_ASSERT_NOW(a_done_idle, m_tvalid && m_tdata[4], !m_tdata[3], "done flagged while busy")
    // Idle bus lines rest high.
    `GSP_ASSERT_NOW(a_idle_lines, m_tvalid && !m_tdata[3], m_tdata[1] && m_tdata[2], "idle lines not high")

endmodule

// ===== tb/gsp_poll_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the gamepad poller: predicts line levels and published bytes per request.
module gsp_poll_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [gsp_pkg::OUT_TDATA_W-1:0] m_tdata,
    output int          fail_count,
    output int          pending
);

    // expected line levels and published bytes, oldest first
    gsp_pkg::result_t poll_view_q [$];

    logic [15:0]    half_period;
    logic           polling;
    logic           low_phase;
    logic [15:0]    tick_cnt;
    logic [2:0]     bit_idx;
    logic [3:0]     byte_idx;
    gsp_pkg::byte_t rx_shift;
    gsp_pkg::byte_t captured [gsp_pkg::RESP_BYTES];
    gsp_pkg::byte_t shown    [gsp_pkg::RESP_BYTES];
    int             results_seen = 0;

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("ERROR: result %0d: %s", results_seen, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    // Advance the poll sequencer by one tick and return the view after it.
    task automatic step_poll(input logic start, input logic din,
                             output gsp_pkg::result_t view);
        logic [16:0]    nxt;
        logic [16:0]    hp;
        logic           fin;
        gsp_pkg::byte_t cmd_b;
        fin = 1'b0;
        hp  = (half_period == 16'd0) ? 17'd1 : {1'b0, half_period};
        if (!polling)
        begin
            if (start)
            begin
                polling   = 1'b1;
                low_phase = 1'b0;
                tick_cnt  = '0;
                bit_idx   = '0;
                byte_idx  = '0;
                rx_shift  = '0;
            end
        end
        else
        begin
            nxt = {1'b0, tick_cnt} + 17'd1;
            if (nxt >= hp)
            begin
                tick_cnt = '0;
                if (!low_phase)
                    low_phase = 1'b1;
                else
                begin
                    // end of the low phase: sample the data line
                    low_phase = 1'b0;
                    rx_shift[bit_idx] = rx_shift[bit_idx] | din;
                    if (bit_idx != gsp_pkg::LAST_BIT)
                        bit_idx = bit_idx + 3'd1;
                    else
                    begin
                        // bytes 0 and 2 of the response are dropped
                        if (byte_idx == gsp_pkg::MODE_BYTE)
                            captured[0] = rx_shift;
                        else if (byte_idx >= gsp_pkg::FIRST_KEPT &&
                                 byte_idx <= gsp_pkg::LAST_KEPT)
                            captured[3'(byte_idx - 4'd2)] = rx_shift;
                        bit_idx  = '0;
                        rx_shift = '0;
                        byte_idx = byte_idx + 4'd1;
                        if (byte_idx >= gsp_pkg::CMD_BYTES)
                        begin
                            polling  = 1'b0;
                            byte_idx = '0;
                            fin      = 1'b1;
                            shown    = captured;
                        end
                    end
                end
            end
            else
                tick_cnt = nxt[15:0];
        end

        case (byte_idx)
            4'd0:    cmd_b = gsp_pkg::CMD_START;
            4'd1:    cmd_b = gsp_pkg::CMD_POLL;
            default: cmd_b = gsp_pkg::CMD_IDLE;
        endcase

        view.cs_n     = !polling;
        view.clk_line = !(polling && low_phase);
        view.cmd_line = polling ? cmd_b[bit_idx] : 1'b1;
        view.busy     = polling;
        view.done     = fin;
        view.mode_id  = shown[0];
        view.buttons  = {shown[2], shown[1]};
        view.right_x  = shown[3];
        view.right_y  = shown[4];
        view.left_x   = shown[5];
        view.left_y   = shown[6];
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        gsp_pkg::result_t want;
        gsp_pkg::result_t got;
        if (!rst_n)
        begin
            half_period = gsp_pkg::HALF_PERIOD_RESET;
            polling     = 1'b0;
            low_phase   = 1'b0;
            tick_cnt    = '0;
            bit_idx     = '0;
            byte_idx    = '0;
            rx_shift    = '0;
            for (int i = 0; i < gsp_pkg::RESP_BYTES; i++)
            begin
                captured[i] = '0;
                shown[i]    = '0;
            end
            poll_view_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (poll_view_q.size() == 0)
                    report_mismatch("result with no request waiting");
                else
                begin
                    want         = poll_view_q.pop_front();
                    got.cs_n     = m_tdata[0];
                    got.clk_line = m_tdata[1];
                    got.cmd_line = m_tdata[2];
                    got.busy     = m_tdata[3];
                    got.done     = m_tdata[4];
                    got.mode_id  = m_tdata[12:5];
                    got.buttons  = m_tdata[28:13];
                    got.right_x  = m_tdata[36:29];
                    got.right_y  = m_tdata[44:37];
                    got.left_x   = m_tdata[52:45];
                    got.left_y   = m_tdata[60:53];
                    check_field("cs_n", 16'(got.cs_n), 16'(want.cs_n));
                    check_field("clk_line", 16'(got.clk_line), 16'(want.clk_line));
                    check_field("cmd_line", 16'(got.cmd_line), 16'(want.cmd_line));
                    check_field("busy_res", 16'(got.busy), 16'(want.busy));
                    check_field("done_res", 16'(got.done), 16'(want.done));
                    check_field("mode_id", 16'(got.mode_id), 16'(want.mode_id));
                    check_field("buttons", got.buttons, want.buttons);
                    check_field("right_x", 16'(got.right_x), 16'(want.right_x));
                    check_field("right_y", 16'(got.right_y), 16'(want.right_y));
                    check_field("left_x", 16'(got.left_x), 16'(want.left_x));
                    check_field("left_y", 16'(got.left_y), 16'(want.left_y));
                end
                results_seen++;
            end
            if (cfg_we)
                half_period = cfg_wdata;
            if (s_tvalid && s_tready)
            begin
                step_poll(s_tuser, s_tdata[0], want);
                poll_view_q.push_back(want);
            end
        end
        pending = poll_view_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the gamepad poller: clock, reset, request and result traffic, verdict.
module tb_top;

    // Cycles with no handshake on either stream before the run is declared hung.
    localparam int QUIET_LIMIT = 1000;
    // One poll: 9 bytes x 8 bits x 2 half periods after the start tick.
    localparam int POLL_HALVES = 144;
    // One long receiver hold-off, early enough to land inside a poll.
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 64;
    // Stop launching random phases once this many requests went in.
    localparam int REQ_TARGET  = 2000;

    typedef enum {DIN_RANDOM, DIN_ZEROS, DIN_ONES} din_mode_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [0] data_in, [7:1] zero
    logic        s_tuser;   // [0] func: 0 tick, 1 start poll
    logic        m_tvalid;
    logic        m_tready;
    logic [gsp_pkg::OUT_TDATA_W-1:0] m_tdata;
    // m_tdata fields, lowest bit up: [0] cs_n, [1] clk_line, [2] cmd_line, [3] busy_res,
    // [4] done_res, [12:5] mode_id, [28:13] buttons, [36:29] right_x, [44:37] right_y,
    // [52:45] left_x, [60:53] left_y, [63:61] zero

    int fail_count;
    int pending;
    bit pace_gaps = 1'b1;   // random gaps on both sides when set
    int sent_reqs = 0;
    int taken     = 0;
    bit hold_done = 1'b0;
    int quiet     = 0;

    always #5 clk = ~clk;

    gamepad_serial_poll uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    gsp_poll_checker poll_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Offer one request and hold it until the block takes it. Leave tvalid
    // high afterwards so back-to-back requests need no extra edge.
    task automatic send_req(input logic start, input logic din);
        int gap;
        gap = pace_gaps ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= start;
        s_tdata  <= {7'b0, din};
        do
            @(posedge clk);
        while (!s_tready);
        sent_reqs++;
    endtask

    // Drop the request stream and wait until every expected result came back.
    // Sample the count on the falling edge so the scoreboard update has settled.
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // Write the half period; only called with the block idle and drained.
    task automatic write_half_period(input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Send a start, then exactly enough ticks to finish the poll. About one
    // tick in eight carries a start too, which the block must ignore.
    task automatic run_poll(input int hp, input din_mode_t mode);
        int  ticks;
        logic din;
        ticks = POLL_HALVES * ((hp == 0) ? 1 : hp);
        din = (mode == DIN_RANDOM) ? 1'($urandom_range(0, 1)) : (mode == DIN_ONES);
        send_req(1'b1, din);
        for (int i = 0; i < ticks; i++)
        begin
            din = (mode == DIN_RANDOM) ? 1'($urandom_range(0, 1)) : (mode == DIN_ONES);
            send_req($urandom_range(0, 7) == 0, din);
        end
    endtask

    // Request side: directed opening, then random phases over half periods.
    initial
    begin
        int hp;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // plain ticks at the reset half period, both data levels
        send_req(1'b0, 1'b0);
        send_req(1'b0, 1'b1);
        send_req(1'b0, 1'b1);
        drain();

        // largest half period: idle ticks only, a poll would never end in time
        write_half_period(16'hFFFF);
        send_req(1'b0, 1'b1);
        send_req(1'b0, 1'b0);
        drain();

        // zero half period acts as one; all-ones response, then a back-to-back
        // start right after done with an all-zeros response
        write_half_period(16'h0000);
        run_poll(0, DIN_ONES);
        run_poll(0, DIN_ZEROS);
        drain();

        write_half_period(16'd1);
        run_poll(1, DIN_RANDOM);
        drain();

        // random phases: mostly short half periods, a few longer ones
        while (sent_reqs < REQ_TARGET)
        begin
            hp = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
            pace_gaps = ($urandom_range(0, 3) != 0);
            write_half_period(hp[15:0]);
            repeat ($urandom_range(1, 3))
            begin
                if (sent_reqs < REQ_TARGET)
                begin
                    // idle noise between polls, sometimes none at all
                    repeat ($urandom_range(0, 3))
                        send_req(1'b0, 1'($urandom_range(0, 1)));
                    run_poll(hp, DIN_RANDOM);
                    // now and then pause the sender until everything came back
                    if ($urandom_range(0, 3) == 0)
                        drain();
                end
            end
            drain();
        end

        drain();
        // spare edges after the drain catch any stray result
        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Result side: random ready gaps, plus one long hold-off so the block
    // fills up and back-pressures the request stream.
    initial
    begin
        int gap;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = pace_gaps ? $urandom_range(0, 3) : 0;
            if (!hold_done && taken >= HOLD_AT)
            begin
                gap       = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            taken++;
        end
    end

    // Watchdog: count edges with no handshake on either stream.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("ERROR: no handshake for %0d cycles", QUIET_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule

// ===== gamepad_serial_poll.f =====
+incdir+hw/rtl
hw/rtl/gsp_pkg.sv
hw/rtl/gsp_engine.sv
hw/rtl/gamepad_serial_poll.sv
tb/gsp_poll_checker.sv
tb/tb_top.sv
